// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication in the next cycle, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/pwl_pkg.sv -----
// types and constants of the piecewise linear profile sampler
package pwl_pkg;

    localparam int TEMP_W  = 9;
    localparam int TIME_W  = 10;
    localparam int QUERY_W = 9;

    localparam logic [TEMP_W-1:0] END_LEVEL_RESET = 9'd50;

    typedef struct packed {
        logic [TEMP_W-1:0]  temp_a;
        logic [TEMP_W-1:0]  temp_b;
        logic [TEMP_W-1:0]  temp_c;
        logic [TEMP_W-1:0]  temp_d;
        logic [TEMP_W-1:0]  temp_e;
        logic [TIME_W-1:0]  time_a;
        logic [TIME_W-1:0]  time_b;
        logic [TIME_W-1:0]  time_c;
        logic [TIME_W-1:0]  time_d;
        logic [TIME_W-1:0]  time_e;
        logic [QUERY_W-1:0] query_pos;
    } in_word_t;

    typedef struct packed {
        logic [TEMP_W-1:0] level;
        logic [TEMP_W-1:0] axis_max;
    } out_word_t;

endpackage

// ----- hw/rtl/piecewise_linear_profile_sampler.sv -----
// piecewise linear profile sampler: sort, segment pick, multiply, pipelined divide
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_data  (pwl_pkg::in_word_t)
//  out       output     out_valid / out_ready  out_data (pwl_pkg::out_word_t)
//  cfg       input      cfg_wr_en              cfg_wr_data (end level, 9 bit)
//
// one word enters per cycle unless the output word waits
// the pipe holds the 9 one-bit stages of the rounding divider plus 6 other stages
// reset (rst_n low, asynchronous) empties the pipe and sets the end level to 50
// one global enable moves every stage; it is low only while the output word
// waits, so a stall freezes the whole pipe and nothing is lost or repeated
`include "assert_macros.svh"

module piecewise_linear_profile_sampler #(
    parameter int POINT_COUNT = 350
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [8:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pwl_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pwl_pkg::out_word_t   out_data
);

    localparam int TW = pwl_pkg::TIME_W;
    localparam int YW = pwl_pkg::TEMP_W;
    localparam logic [TW-1:0] LAST = TW'(POINT_COUNT - 1);
    localparam int REM_W = 19;     // holds 511 * 1023 + 511
    localparam int DIV_STAGES = YW;

    // stage 1: clamped points
    typedef struct packed {
        logic [4:0][TW-1:0] x;
        logic [4:0][YW-1:0] y;
        logic [TW-1:0]      q;
        logic [YW-1:0]      ymax;
        logic [YW-1:0]      e;
    } pts_t;

    // stage 3: chosen segment
    typedef struct packed {
        logic [TW-1:0]        dx;
        logic [TW-1:0]        dq;
        logic signed [TW-1:0] dy;
        logic [YW-1:0]        y0;
        logic [YW-1:0]        ymax;
    } seg_t;

    // stage 4: product
    typedef struct packed {
        logic signed [20:0] prod;
        logic [TW-1:0]      dx;
        logic [YW-1:0]      y0;
        logic [YW-1:0]      ymax;
    } mul_t;

    // divider stage
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [YW-1:0]    quo;
        logic [TW-1:0]    dx;
        logic             neg;
        logic             zd;
        logic [YW-1:0]    y0;
        logic [YW-1:0]    ymax;
    } div_t;

    logic [YW-1:0] end_level_reg;
    logic          pipe_en;

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    pts_t   p1_reg, p1_next;
    pts_t   p2_reg, p2_next;
    seg_t   p3_reg, p3_next;
    mul_t   p4_reg, p4_next;
    logic   dv_reg [0:DIV_STAGES];
    div_t   d_reg  [0:DIV_STAGES];
    div_t   d_next [0:DIV_STAGES];
    logic   out_valid_reg;
    pwl_pkg::out_word_t out_data_reg, out_data_next;

    // whole pipe moves unless the output word is held
    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_level_reg <= pwl_pkg::END_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            end_level_reg <= cfg_wr_data;
        end
    end

    // stage 1: clamp times and query, axis maximum
    always_comb
    begin
        logic [YW-1:0] m;
        logic [4:0][TW-1:0] tx;
        logic [4:0][YW-1:0] ty;
        logic [TW-1:0] qx;
        tx = {in_data.time_e, in_data.time_d, in_data.time_c, in_data.time_b, in_data.time_a};
        ty = {in_data.temp_e, in_data.temp_d, in_data.temp_c, in_data.temp_b, in_data.temp_a};
        m = end_level_reg;
        for (int i = 0; i < 5; i++)
        begin
            p1_next.x[i] = (tx[i] > LAST) ? LAST : tx[i];
            p1_next.y[i] = ty[i];
            if (ty[i] > m)
            begin
                m = ty[i];
            end
        end
        qx = TW'(in_data.query_pos);
        p1_next.q    = (qx > LAST) ? LAST : qx;
        p1_next.ymax = (m == '0) ? YW'(1) : m;
        p1_next.e    = end_level_reg;
    end

    // stage 2: stable sort by rank, final point forced to end level at the last position
    always_comb
    begin
        logic [2:0] rank [5];
        p2_next = p1_reg;
        for (int i = 0; i < 5; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < 5; j++)
            begin
                if ((j < i && p1_reg.x[j] <= p1_reg.x[i]) ||
                    (j > i && p1_reg.x[j] <  p1_reg.x[i]))
                begin
                    rank[i] = rank[i] + 3'd1;
                end
            end
        end
        for (int p = 0; p < 5; p++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                if (rank[i] == 3'(p))
                begin
                    p2_next.x[p] = p1_reg.x[i];
                    p2_next.y[p] = p1_reg.y[i];
                end
            end
        end
        if (p2_next.x[4] == LAST)
        begin
            p2_next.y[4] = p1_reg.e;
        end
    end

    // stage 3: last segment whose start is at or before the query
    always_comb
    begin
        logic [6:0][TW-1:0] kx;
        logic [6:0][YW-1:0] ky;
        logic [2:0] s;
        kx = {LAST, p2_reg.x, TW'(0)};
        ky = {p2_reg.e, p2_reg.y, p2_reg.e};
        s = '0;
        for (int i = 1; i < 6; i++)
        begin
            if (kx[i] <= p2_reg.q)
            begin
                s = s + 3'd1;
            end
        end
        p3_next.dx   = kx[s + 3'd1] - kx[s];
        p3_next.dq   = p2_reg.q - kx[s];
        p3_next.ymax = p2_reg.ymax;
        if (kx[s + 3'd1] == kx[s])
        begin
            // zero length segment: value is its end point
            p3_next.y0 = ky[s + 3'd1];
            p3_next.dy = '0;
        end
        else
        begin
            p3_next.y0 = ky[s];
            p3_next.dy = $signed({1'b0, ky[s + 3'd1]}) - $signed({1'b0, ky[s]});
        end
    end

    // stage 4: slope times offset
    always_comb
    begin
        p4_next.prod = p3_reg.dy * $signed({1'b0, p3_reg.dq});
        p4_next.dx   = p3_reg.dx;
        p4_next.y0   = p3_reg.y0;
        p4_next.ymax = p3_reg.ymax;
    end

    // divider entry: magnitude plus half divisor, rounds half away from zero
    always_comb
    begin
        logic [20:0] mag;
        mag = p4_reg.prod[20] ? 21'(-p4_reg.prod) : 21'(p4_reg.prod);
        d_next[0].rem  = mag[REM_W-1:0] + REM_W'(p4_reg.dx >> 1);
        d_next[0].quo  = '0;
        d_next[0].dx   = p4_reg.dx;
        d_next[0].neg  = p4_reg.prod[20];
        d_next[0].zd   = (p4_reg.dx == '0);
        d_next[0].y0   = p4_reg.y0;
        d_next[0].ymax = p4_reg.ymax;
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_comb
        begin
            logic [REM_W-1:0] trial;
            trial = REM_W'(d_reg[k].dx) << (DIV_STAGES - 1 - k);
            d_next[k + 1] = d_reg[k];
            if (d_reg[k].rem >= trial)
            begin
                d_next[k + 1].rem = d_reg[k].rem - trial;
                d_next[k + 1].quo[DIV_STAGES - 1 - k] = 1'b1;
            end
        end
    end

    // final: apply sign, add base, clamp to axis range
    always_comb
    begin
        logic signed [YW+1:0] sq;
        logic signed [YW+1:0] yv;
        div_t f;
        f  = d_reg[DIV_STAGES];
        sq = f.zd ? '0 : $signed({2'b00, f.quo});
        if (f.neg)
        begin
            sq = -sq;
        end
        yv = $signed({2'b00, f.y0}) + sq;
        if (yv < 0)
        begin
            out_data_next.level = '0;
        end
        else if (yv > $signed({2'b00, f.ymax}))
        begin
            out_data_next.level = f.ymax;
        end
        else
        begin
            out_data_next.level = yv[YW-1:0];
        end
        out_data_next.axis_max = f.ymax;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                dv_reg[k + 1] <= dv_reg[k];
            end
            out_valid_reg <= dv_reg[DIV_STAGES];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            d_reg[0] <= d_next[0];
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                d_reg[k + 1] <= d_next[k + 1];
            end
            out_data_reg <= out_data_next;
        end
    end

    `ASSERT_SAME(a_level_in_range, clk, rst_n, out_valid, out_data.level <= out_data.axis_max)
    `ASSERT_SAME(a_axis_nonzero, clk, rst_n, out_valid, out_data.axis_max != '0)
    `ASSERT_NEXT(a_flow, clk, rst_n, pipe_en && dv_reg[DIV_STAGES], out_valid)

endmodule
